### rtl/keypad_key_list_tracker_defines.svh
// Assertion macros used by the key list tracker top level.
`ifndef KEYPAD_KEY_LIST_TRACKER_DEFINES_SVH
`define KEYPAD_KEY_LIST_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define KLLT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key list tracker check failed");

// Next-cycle implication, checked on clk, off while in reset.
`define KLLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key list tracker check failed");

`endif

### rtl/kllt_pkg.sv
// Package: shared types and constants of the key list tracker.
`timescale 1ns / 1ps

package kllt_pkg;

	localparam int SLOTS = 10;
	localparam int SLOT_W = 4;
	localparam int CODE_W = 8;
	localparam int POS_W = 8;
	localparam int TIME_W = 32;
	localparam int HOLD_W = 16;
	localparam logic [HOLD_W-1:0] HOLD_TIME_RESET = 16'd500;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_PRESSED  = 2'd1,
		ST_HOLD     = 2'd2,
		ST_RELEASED = 2'd3
	} key_state_t;

	// Priority chain running from slot 0 upwards.
	typedef struct packed {
		logic hit;  // an earlier slot holds this position
		logic free; // an earlier slot is empty
	} chain_t;

	// What one slot reports for the current request.
	typedef struct packed {
		logic              ev;
		logic              load_hold;
		logic              changed;
		key_state_t        state;
		logic [CODE_W-1:0] code;
	} slot_rpt_t;

endpackage

### rtl/keypad_key_list_tracker.sv
// Module: top level of the keypad key list tracker, a chain of key slots.
`timescale 1ns / 1ps
`include "keypad_key_list_tracker_defines.svh"

// Keypad key list tracker.
// Input channel (in_valid / in_stall): one request per scanned matrix
// position, with its key code, contact state, millisecond time and scan
// markers. Output channel (out_valid / out_stall): one result per request,
// giving the slot event (if any) and, on the last position of a scan, the
// activity flag.
// The slots form a row of cells; a priority chain through them finds the
// lowest matching slot and the lowest empty slot in the same cycle.
// The result of an accepted request is registered and appears in the cycle after.
// Throughput: one request per cycle while the input is not stalled, set by the
// single pass through the slot chain and the shared hold timer compare.
// A stalled result is held in the output register; the input is stalled
// only while that register is full and the receiver stalls.
// Reset empties every slot, clears the hold timer, loads the hold time with
// 500 ms and leaves the output register empty. The user writes the hold time
// via cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.

module keypad_key_list_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  key_position,
	input  logic [7:0]  key_code,
	input  logic        pressed,
	input  logic [31:0] now_ms,
	input  logic        first_of_scan,
	input  logic        last_of_scan,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_valid,
	output logic [3:0]  event_slot,
	output logic [7:0]  event_code,
	output logic [1:0]  event_state,
	output logic        any_activity,
	output logic        scan_done
);

	logic [kllt_pkg::HOLD_W-1:0] hold_time_q;
	logic [kllt_pkg::TIME_W-1:0] hold_start_q;
	logic                        out_valid_q;

	logic                        accept;
	logic                        hold_expired;
	logic                        hit_any;
	logic [kllt_pkg::TIME_W-1:0] elapsed;

	kllt_pkg::chain_t    chain [kllt_pkg::SLOTS+1];
	kllt_pkg::slot_rpt_t rpt   [kllt_pkg::SLOTS];

	logic                          ev_any;
	logic                          load_hold;
	logic                          activity;
	logic [kllt_pkg::SLOT_W-1:0]   ev_slot;
	logic [kllt_pkg::CODE_W-1:0]   ev_code;
	logic [1:0]                    ev_state;

	// Take a request unless a finished result is held back by the receiver.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// One shared hold timer: elapsed time wraps modulo 2^32.
	assign elapsed      = now_ms - hold_start_q;
	assign hold_expired = (elapsed > {{(kllt_pkg::TIME_W-kllt_pkg::HOLD_W){1'b0}}, hold_time_q});

	assign chain[0].hit  = 1'b0;
	assign chain[0].free = 1'b0;
	assign hit_any       = chain[kllt_pkg::SLOTS].hit;

	for (genvar g = 0; g < kllt_pkg::SLOTS; g++) begin : g_slot
		kllt_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.step_en      (accept),
			.key_position (key_position),
			.key_code     (key_code),
			.pressed      (pressed),
			.first_of_scan(first_of_scan),
			.hit_any      (hit_any),
			.hold_expired (hold_expired),
			.chain_i      (chain[g]),
			.chain_o      (chain[g+1]),
			.rpt          (rpt[g])
		);
	end

	// At most one slot reports an event, so OR the masked fields together.
	always_comb begin
		ev_any    = 1'b0;
		load_hold = 1'b0;
		activity  = 1'b0;
		ev_slot   = '0;
		ev_code   = '0;
		ev_state  = '0;
		for (int i = 0; i < kllt_pkg::SLOTS; i++) begin
			ev_any    = ev_any | rpt[i].ev;
			load_hold = load_hold | rpt[i].load_hold;
			activity  = activity | rpt[i].changed;
			if (rpt[i].ev) begin
				ev_slot  = ev_slot | kllt_pkg::SLOT_W'(i);
				ev_code  = ev_code | rpt[i].code;
				ev_state = ev_state | rpt[i].state;
			end
		end
	end

	// Hold the hold time register; write it straight from the config port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q <= kllt_pkg::HOLD_TIME_RESET;
		end else if (cfg_wr_en) begin
			hold_time_q <= cfg_wr_data;
		end
	end

	// Restart the shared timer when a key enters pressed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_start_q <= '0;
		end else if (accept && load_hold) begin
			hold_start_q <= now_ms;
		end
	end

	// Advance the output register: fill on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			event_valid  <= ev_any;
			event_slot   <= ev_slot;
			event_code   <= ev_code;
			event_state  <= ev_state;
			any_activity <= last_of_scan && activity;
			scan_done    <= last_of_scan;
		end
	end

	assign out_valid = out_valid_q;

	`KLLT_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
	`KLLT_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid)
	`KLLT_ASSERT_NOW(a_activity_on_last, out_valid && !scan_done, !any_activity)
	`KLLT_ASSERT_NOW(a_no_event_zero, out_valid && !event_valid, (event_slot == '0) && (event_code == '0))

endmodule

### rtl/kllt_cell.sv
// Module: one key slot of the tracker chain with its own key state machine.
`timescale 1ns / 1ps

module kllt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  logic [kllt_pkg::POS_W-1:0]  key_position,
	input  logic [kllt_pkg::CODE_W-1:0] key_code,
	input  logic                       pressed,
	input  logic                       first_of_scan,
	input  logic                       hit_any,
	input  logic                       hold_expired,
	input  kllt_pkg::chain_t           chain_i,
	output kllt_pkg::chain_t           chain_o,
	output kllt_pkg::slot_rpt_t        rpt
);

	logic [kllt_pkg::CODE_W-1:0] code_q;
	logic [kllt_pkg::POS_W-1:0]  pos_q;
	kllt_pkg::key_state_t        state_q;
	logic                        changed_q;

	logic                        cleared;
	logic [kllt_pkg::CODE_W-1:0] eff_code;
	logic                        eff_changed;
	logic                        occupied;
	logic                        match;
	logic                        take_match;
	logic                        take_alloc;
	logic                        match_ev;
	kllt_pkg::key_state_t        step_state;

	// Idle slots are emptied at the start of a scan.
	assign cleared     = first_of_scan && (state_q == kllt_pkg::ST_IDLE);
	assign eff_code    = cleared ? '0 : code_q;
	assign eff_changed = cleared ? 1'b0 : changed_q;
	assign occupied    = (eff_code != '0);
	assign match       = occupied && (pos_q == key_position);

	assign chain_o.hit  = chain_i.hit | match;
	assign chain_o.free = chain_i.free | ~occupied;

	assign take_match = (key_code != '0) && match && !chain_i.hit;
	assign take_alloc = (key_code != '0) && pressed && !hit_any && !occupied && !chain_i.free;

	always_comb begin
		unique case (state_q)
			kllt_pkg::ST_IDLE: begin
				step_state = pressed ? kllt_pkg::ST_PRESSED : kllt_pkg::ST_IDLE;
			end
			kllt_pkg::ST_PRESSED: begin
				if (hold_expired)
					step_state = kllt_pkg::ST_HOLD;
				else if (!pressed)
					step_state = kllt_pkg::ST_RELEASED;
				else
					step_state = kllt_pkg::ST_PRESSED;
			end
			kllt_pkg::ST_HOLD: begin
				step_state = pressed ? kllt_pkg::ST_HOLD : kllt_pkg::ST_RELEASED;
			end
			kllt_pkg::ST_RELEASED: begin
				step_state = kllt_pkg::ST_IDLE;
			end
			default: begin
				step_state = kllt_pkg::ST_IDLE;
			end
		endcase
	end

	assign match_ev = take_match && (step_state != state_q);

	always_comb begin
		rpt.ev        = match_ev | take_alloc;
		rpt.load_hold = take_alloc |
			(take_match && pressed && (state_q == kllt_pkg::ST_IDLE));
		rpt.state     = take_alloc ? kllt_pkg::ST_PRESSED : step_state;
		rpt.code      = take_alloc ? key_code : eff_code;
		if (take_alloc)
			rpt.changed = 1'b1;
		else if (take_match)
			rpt.changed = match_ev;
		else
			rpt.changed = eff_changed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q    <= '0;
			pos_q     <= '0;
			state_q   <= kllt_pkg::ST_IDLE;
			changed_q <= 1'b0;
		end else if (step_en) begin
			code_q    <= take_alloc ? key_code : eff_code;
			changed_q <= rpt.changed;
			if (take_alloc) begin
				pos_q   <= key_position;
				state_q <= kllt_pkg::ST_PRESSED;
			end else if (take_match) begin
				state_q <= step_state;
			end
		end
	end

endmodule
